// ----- hw/rtl/etfp_pkg.sv -----
`timescale 1ns / 1ps

package etfp_pkg;

    localparam int POS_W = 5;
    localparam int TDATA_W = 128;

    localparam logic [POS_W-1:0] FRAME_LEN = 5'd22;
    localparam logic [POS_W-1:0] CRC_SPAN = 5'd20;

    // byte offsets inside a frame
    localparam logic [POS_W-1:0] POS_HDR0 = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1 = 5'd1;
    localparam logic [POS_W-1:0] POS_HDR2 = 5'd2;
    localparam logic [POS_W-1:0] POS_THR = 5'd7;
    localparam logic [POS_W-1:0] POS_CUR_LO = 5'd8;
    localparam logic [POS_W-1:0] POS_CUR_HI = 5'd9;
    localparam logic [POS_W-1:0] POS_VOLT_LO = 5'd10;
    localparam logic [POS_W-1:0] POS_VOLT_HI = 5'd11;
    localparam logic [POS_W-1:0] POS_CONS_LO = 5'd12;
    localparam logic [POS_W-1:0] POS_CONS_HI = 5'd13;
    localparam logic [POS_W-1:0] POS_TEMP = 5'd14;
    localparam logic [POS_W-1:0] POS_PWR = 5'd15;
    localparam logic [POS_W-1:0] POS_RPM_LO = 5'd17;
    localparam logic [POS_W-1:0] POS_RPM_HI = 5'd18;
    localparam logic [POS_W-1:0] POS_STATUS = 5'd19;
    localparam logic [POS_W-1:0] POS_CRC_LO = 5'd20;
    localparam logic [POS_W-1:0] POS_CRC_HI = 5'd21;

    localparam logic [7:0] HDR0 = 8'h55;
    localparam logic [7:0] HDR1 = 8'h00;
    localparam logic [7:0] HDR2 = 8'd22;

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    typedef struct packed {
        logic [15:0] rpm;
        logic [15:0] voltage_tenths;
        logic [15:0] current_tenths;
        logic [15:0] consumption_hundredths;
        logic [7:0]  temperature;
        logic [6:0]  power_level;
        logic [6:0]  throttle_level;
        logic [7:0]  status_byte;
        logic [31:0] sync_total;
    } result_t;

    // reflected crc, one byte folded in
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/etfp_frame_core.sv -----
`timescale 1ns / 1ps

module etfp_frame_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_accept,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output etfp_pkg::result_t res_data
);
    import etfp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [31:0]      sync_reg, sync_next;
    logic [POS_W-1:0] idx;
    logic [15:0]      crc_step;

    logic [7:0] crc_lo_reg;
    logic [7:0] cur_lo_reg, cur_hi_reg;
    logic [7:0] volt_lo_reg, volt_hi_reg;
    logic [7:0] cons_lo_reg, cons_hi_reg;
    logic [7:0] rpm_lo_reg, rpm_hi_reg;
    logic [7:0] temp_reg, status_reg;
    logic [6:0] pwr_reg, thr_reg;

    assign idx = (pos_reg >= FRAME_LEN) ? POS_HDR0 : pos_reg;
    assign crc_step = crc_byte((idx == POS_HDR0) ? CRC_INIT : crc_reg, rx_byte);

    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        sync_next = sync_reg;
        res_valid = 1'b0;
        if (beat_accept) begin
            if (idx == POS_HDR0) begin
                pos_next = (rx_byte == HDR0) ? POS_HDR1 : POS_HDR0;
                crc_next = crc_step;
            end else if (idx == POS_HDR1) begin
                pos_next = (rx_byte == HDR1) ? POS_HDR2 : POS_HDR0;
                crc_next = crc_step;
            end else if (idx == POS_HDR2) begin
                if (rx_byte == HDR2) begin
                    pos_next = 5'(idx + 5'd1);
                    sync_next = sync_reg + 32'd1;
                end else begin
                    pos_next = POS_HDR0;
                end
                crc_next = crc_step;
            end else if (idx < CRC_SPAN) begin
                pos_next = 5'(idx + 5'd1);
                crc_next = crc_step;
            end else if (idx == POS_CRC_LO) begin
                pos_next = POS_CRC_HI;
            end else begin
                // last byte: check the little-endian crc word
                pos_next = POS_HDR0;
                res_valid = (crc_reg == {rx_byte, crc_lo_reg});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HDR0;
            crc_reg <= CRC_INIT;
            sync_reg <= 32'd0;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            sync_reg <= sync_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_accept) begin
            case (idx)
                POS_THR:     thr_reg <= rx_byte[7:1];
                POS_CUR_LO:  cur_lo_reg <= rx_byte;
                POS_CUR_HI:  cur_hi_reg <= rx_byte;
                POS_VOLT_LO: volt_lo_reg <= rx_byte;
                POS_VOLT_HI: volt_hi_reg <= rx_byte;
                POS_CONS_LO: cons_lo_reg <= rx_byte;
                POS_CONS_HI: cons_hi_reg <= rx_byte;
                POS_TEMP:    temp_reg <= rx_byte;
                POS_PWR:     pwr_reg <= rx_byte[7:1];
                POS_RPM_LO:  rpm_lo_reg <= rx_byte;
                POS_RPM_HI:  rpm_hi_reg <= rx_byte;
                POS_STATUS:  status_reg <= rx_byte;
                POS_CRC_LO:  crc_lo_reg <= rx_byte;
                default: ;
            endcase
        end
    end

    always_comb begin
        res_data.rpm = {rpm_hi_reg, rpm_lo_reg};
        res_data.voltage_tenths = {volt_hi_reg, volt_lo_reg};
        res_data.current_tenths = {cur_hi_reg, cur_lo_reg};
        res_data.consumption_hundredths = {cons_hi_reg, cons_lo_reg};
        res_data.temperature = temp_reg;
        res_data.power_level = pwr_reg;
        res_data.throttle_level = thr_reg;
        res_data.status_byte = status_reg;
        res_data.sync_total = sync_reg;
    end

endmodule

// ----- hw/rtl/etfp_out_buf.sv -----
`timescale 1ns / 1ps

module etfp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  etfp_pkg::result_t res_data,
    output logic              res_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output etfp_pkg::result_t m_data
);
    import etfp_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign res_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            // output stalled, park the result
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (res_valid) begin
                out_reg <= res_data;
            end
        end else if (res_valid) begin
            skid_reg <= res_data;
        end
    end

endmodule

// ----- hw/rtl/esc_telemetry_frame_parser.sv -----
`timescale 1ns / 1ps
// a result is registered in the output buffer (out_reg, or skid_reg while m_ stalls)
// throughput: one byte per cycle while s_tready is high (byte-wide crc update in core)
// a two-entry output buffer keeps s_tready high while one result waits on m_
// reset (aresetn low, synchronous) clears byte position, crc, sync count and buffer valids
// s_tready is high from the first cycle after reset

module esc_telemetry_frame_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] rpm, [31:16] voltage_tenths, [47:32] current_tenths,
    // [63:48] consumption_hundredths, [71:64] temperature, [78:72] power_level,
    // [85:79] throttle_level, [93:86] status_byte, [125:94] sync_total, [127:126] zero
    output logic [etfp_pkg::TDATA_W-1:0]    m_tdata
);
    import etfp_pkg::*;

    logic    beat_accept;
    logic    res_valid;
    logic    res_ready;
    result_t res_data;
    result_t m_data;

    assign s_tready = res_ready;
    assign beat_accept = s_tvalid && s_tready;

    etfp_frame_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (beat_accept),
        .rx_byte     (s_tdata),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    etfp_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (m_data)
    );

    assign m_tdata = {2'b00,
                      m_data.sync_total,
                      m_data.status_byte,
                      m_data.throttle_level,
                      m_data.power_level,
                      m_data.temperature,
                      m_data.consumption_hundredths,
                      m_data.current_tenths,
                      m_data.voltage_tenths,
                      m_data.rpm};

endmodule

// ----- hw/rtl/etfp_checker.sv -----
`timescale 1ns / 1ps

module etfp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [7:0]   s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // stalled result beat stays up
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // input only backs up when a result is already waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with empty output");

    // one byte can cause at most one result, so a stall frees up after one pop
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready)
        else $error("s_tready stuck low after output pop");

endmodule

bind esc_telemetry_frame_parser etfp_checker u_etfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/esc_telemetry_frame_parser_chk.sv -----
`timescale 1ns / 1ps

module esc_telemetry_frame_parser_chk (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] rpm, [31:16] voltage_tenths, [47:32] current_tenths,
    // [63:48] consumption_hundredths, [71:64] temperature, [78:72] power_level,
    // [85:79] throttle_level, [93:86] status_byte, [125:94] sync_total, [127:126] zero
    input  logic [127:0] m_tdata,
    output int           fail_count,
    output int           pending,
    output int           checked,
    output logic [31:0]  headers_seen
);
    import etfp_pkg::*;

    logic [POS_W-1:0] next_pos;
    logic [7:0]       frame_buf [0:21];
    logic [31:0]      sync_cnt;
    result_t          telem_q [$];

    // bit-serial form of the reflected crc over bytes 0..19
    function automatic logic [15:0] frame_crc();
        logic [15:0]      c;
        logic             fb;
        logic [POS_W-1:0] i;
        int               j;
        c = CRC_INIT;
        for (i = '0; i < CRC_SPAN; i++) begin
            for (j = 0; j < 8; j++) begin
                fb = c[0] ^ frame_buf[i][j[2:0]];
                c = c >> 1;
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
        end
        return c;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("mismatch on %s in result %0d: expected 0x%0h, got 0x%0h",
                         what, checked, want_v, got_v);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        logic [POS_W-1:0] p;
        result_t          want;
        if (!aresetn) begin
            next_pos = POS_HDR0;
            sync_cnt = '0;
            telem_q.delete();
            fail_count = 0;
            checked = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                p = (next_pos >= FRAME_LEN) ? POS_HDR0 : next_pos;
                frame_buf[p] = s_tdata;
                case (p)
                    POS_HDR0: begin
                        next_pos = (s_tdata == HDR0) ? POS_HDR1 : POS_HDR0;
                    end
                    POS_HDR1: begin
                        next_pos = (s_tdata == HDR1) ? POS_HDR2 : POS_HDR0;
                    end
                    POS_HDR2: begin
                        if (s_tdata == HDR2) begin
                            sync_cnt = sync_cnt + 32'd1;
                            next_pos = POS_HDR2 + 5'd1;
                        end else begin
                            next_pos = POS_HDR0;
                        end
                    end
                    POS_CRC_HI: begin
                        next_pos = POS_HDR0;
                        if (frame_crc() == {frame_buf[POS_CRC_HI], frame_buf[POS_CRC_LO]}) begin
                            want.rpm = {frame_buf[POS_RPM_HI], frame_buf[POS_RPM_LO]};
                            want.voltage_tenths = {frame_buf[POS_VOLT_HI], frame_buf[POS_VOLT_LO]};
                            want.current_tenths = {frame_buf[POS_CUR_HI], frame_buf[POS_CUR_LO]};
                            want.consumption_hundredths =
                                {frame_buf[POS_CONS_HI], frame_buf[POS_CONS_LO]};
                            want.temperature = frame_buf[POS_TEMP];
                            want.power_level = frame_buf[POS_PWR][7:1];
                            want.throttle_level = frame_buf[POS_THR][7:1];
                            want.status_byte = frame_buf[POS_STATUS];
                            want.sync_total = sync_cnt;
                            telem_q.push_back(want);
                        end
                    end
                    default: begin
                        next_pos = p + 5'd1;
                    end
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (telem_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat 0x%0h with nothing pending", m_tdata);
                    end
                end else begin
                    want = telem_q.pop_front();
                    check_field("rpm", 32'(want.rpm), 32'(m_tdata[15:0]));
                    check_field("voltage_tenths", 32'(want.voltage_tenths),
                                32'(m_tdata[31:16]));
                    check_field("current_tenths", 32'(want.current_tenths),
                                32'(m_tdata[47:32]));
                    check_field("consumption_hundredths", 32'(want.consumption_hundredths),
                                32'(m_tdata[63:48]));
                    check_field("temperature", 32'(want.temperature), 32'(m_tdata[71:64]));
                    check_field("power_level", 32'(want.power_level), 32'(m_tdata[78:72]));
                    check_field("throttle_level", 32'(want.throttle_level),
                                32'(m_tdata[85:79]));
                    check_field("status_byte", 32'(want.status_byte), 32'(m_tdata[93:86]));
                    check_field("sync_total", want.sync_total, m_tdata[125:94]);
                    check_field("pad bits", 32'd0, 32'(m_tdata[127:126]));
                    checked++;
                end
            end
        end
        pending = telem_q.size();
        headers_seen = sync_cnt;
    end

endmodule

// ----- test/esc_telemetry_frame_parser_tb.sv -----
`timescale 1ns / 1ps

module esc_telemetry_frame_parser_tb;
    import etfp_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int BYTE_TARGET = 950;
    localparam int GOOD_TARGET = 25;
    localparam int NO_FLIP = -1;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_MIXED} fill_e;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;   // [7:0] rx_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [15:0] rpm, [31:16] voltage_tenths, [47:32] current_tenths,
    // [63:48] consumption_hundredths, [71:64] temperature, [78:72] power_level,
    // [85:79] throttle_level, [93:86] status_byte, [125:94] sync_total, [127:126] zero
    logic [127:0] m_tdata;

    int           fail_count;
    int           pending;
    int           checked;
    logic [31:0]  headers_seen;

    int           bytes_sent = 0;
    int           good_sent = 0;
    int           bad_sent = 0;
    int           noise_sent = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;

    int unsigned  rx_left = 0;
    logic [1:0]   rx_mode = 2'd0;
    logic [7:0]   rx_mask = 8'hff;
    logic [2:0]   rx_ph = 3'd0;

    esc_telemetry_frame_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    esc_telemetry_frame_parser_chk u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .headers_seen (headers_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: ready always, mostly, on a rotating mask, or seldom
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_left <= $urandom_range(30, 300);
            rx_mode <= 2'($urandom_range(0, 3));
            rx_mask <= 8'($urandom) | 8'h01;
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_ph <= rx_ph + 3'd1;
        case (rx_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= rx_mask[rx_ph];
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // flip >= 0 corrupts one bit of that frame byte
    task automatic send_frame(input fill_e fill, input int flip);
        logic [7:0]       fb [0:21];
        logic [15:0]      crc;
        logic [POS_W-1:0] k;
        logic [POS_W-1:0] fpos;
        fb[POS_HDR0] = HDR0;
        fb[POS_HDR1] = HDR1;
        fb[POS_HDR2] = HDR2;
        for (k = 5'd3; k < CRC_SPAN; k++) begin
            case (fill)
                FILL_ZERO: fb[k] = 8'h00;
                FILL_ONES: fb[k] = 8'hff;
                default: begin
                    case ($urandom_range(0, 3))
                        0: fb[k] = 8'h00;
                        1: fb[k] = 8'hff;
                        default: fb[k] = 8'($urandom);
                    endcase
                end
            endcase
        end
        crc = CRC_INIT;
        for (k = '0; k < CRC_SPAN; k++) begin
            crc = crc_byte(crc, fb[k]);
        end
        fb[POS_CRC_LO] = crc[7:0];
        fb[POS_CRC_HI] = crc[15:8];
        if (flip >= 0) begin
            fpos = POS_W'(flip);
            fb[fpos] = fb[fpos] ^ 8'(1 << $urandom_range(0, 7));
            bad_sent++;
        end else begin
            good_sent++;
        end
        for (k = '0; k < FRAME_LEN; k++) begin
            send_byte(fb[k]);
        end
    endtask

    // hold the sender until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int         n;
        int         k;
        logic [7:0] nb;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_frame(FILL_ZERO, NO_FLIP);
        send_frame(FILL_ONES, NO_FLIP);
        send_frame(FILL_MIXED, int'(POS_CRC_HI));
        send_frame(FILL_MIXED, int'(POS_VOLT_LO));
        // a wrong byte at each header position, then a clean frame
        send_byte(8'h12);
        send_frame(FILL_ONES, NO_FLIP);
        send_byte(HDR0);
        send_byte(8'h01);
        send_frame(FILL_MIXED, NO_FLIP);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(8'h17);
        send_frame(FILL_MIXED, NO_FLIP);
        // second 0x55 is dropped, not taken as a fresh start, so this frame is lost
        send_byte(HDR0);
        send_frame(FILL_ZERO, NO_FLIP);
        send_frame(FILL_MIXED, NO_FLIP);
        drain();

        while ((bytes_sent - noise_sent) < BYTE_TARGET || good_sent < GOOD_TARGET) begin
            n = $urandom_range(0, 99);
            if (n < 70) begin
                send_frame(FILL_MIXED, NO_FLIP);
            end else if (n < 85) begin
                send_frame(fill_e'($urandom_range(0, 2)), $urandom_range(0, 21));
            end else begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    case ($urandom_range(0, 5))
                        0: nb = HDR0;
                        1: nb = HDR1;
                        2: nb = HDR2;
                        default: nb = 8'($urandom);
                    endcase
                    send_byte(nb);
                    noise_sent++;
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                drain();
            end
        end

        drain();
        repeat (20) @(posedge aclk);

        $display("%0d bytes sent: %0d intact frames, %0d corrupted frames, %0d noise bytes",
                 bytes_sent, good_sent, bad_sent, noise_sent);
        $display("%0d telemetry results checked, %0d headers synced, %0d never arrived",
                 checked, headers_seen, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
